// ===== hdl/rlmq_pkg.sv =====
// Shared types and constants for the rate-limited message queue.
package rlmq_pkg;

  localparam int unsigned SlotsDefault = 8;
  localparam int unsigned IdW          = 8;
  localparam int unsigned IntervalW    = 16;
  localparam int unsigned PaddrW       = 3;
  localparam int unsigned PdataW       = 32;

  // Register index, taken from paddr[2]
  localparam logic RegIntervalTicks = 1'b0;

  // Input function codes
  localparam logic FuncArrival = 1'b0;
  localparam logic FuncTick    = 1'b1;

  // Result event codes
  localparam logic EvReleased = 1'b0;
  localparam logic EvDropped  = 1'b1;

  localparam logic [IntervalW-1:0] ElapsedMax = {IntervalW{1'b1}};

  typedef struct packed {
    logic           func;
    logic [IdW-1:0] msg_id;
  } in_item_t;

  typedef struct packed {
    logic           event_res;
    logic [IdW-1:0] msg_id_out;
  } out_item_t;

  // Commands from the controller to the ring
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // Ring status back to the controller
  typedef struct packed {
    logic full;
    logic empty;
  } ring_sts_t;

  typedef enum logic [1:0] {
    StAccept = 2'b01,
    StFetch  = 2'b10
  } ctrl_state_e;

endpackage

// ===== hdl/rlmq_ring.sv =====
// Ring buffer of message identifiers: slot memory plus read and write pointers.
module rlmq_ring #(
  parameter int unsigned Slots = rlmq_pkg::SlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rlmq_pkg::ring_cmd_t         cmd_i,
  input  logic [rlmq_pkg::IdW-1:0]    wr_data_i,
  output rlmq_pkg::ring_sts_t         sts_o,
  output logic [rlmq_pkg::IdW-1:0]    rd_data_o
);

  localparam int unsigned PtrW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(Slots - 1);

  logic [rlmq_pkg::IdW-1:0] mem_q [Slots];
  logic [rlmq_pkg::IdW-1:0] rd_data_q;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_next, rd_next;

  assign wr_next = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;

  assign sts_o.full  = (wr_next == rd_ptr_q);
  assign sts_o.empty = (wr_ptr_q == rd_ptr_q);

  assign wr_ptr_d = cmd_i.push ? wr_next : wr_ptr_q;
  assign rd_ptr_d = cmd_i.pop  ? rd_next : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/rate_limited_message_queue.sv =====
// Rate-limited message queue: top level with control, elapsed counter and APB registers.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per item;
//   func selects a message arrival or one time tick, msg_id is the arriving
//   identifier. Arrivals go into a ring of SLOTS slots (SLOTS-1 usable); an
//   arrival that finds the ring full is dropped and reported.
// A tick advances a saturating elapsed counter; if the ring holds a message
//   and elapsed has reached interval_ticks, the oldest one leaves.
// Output channel (out_valid_o / out_stall_i / out_data_o): one beat per
//   result, event_res (released or dropped) and the identifier.
// interval_ticks sits at APB address 0; write it only while idle.
// Timing: arrivals and non-releasing ticks leave the sequencer in its accept state. A
//   drop result is shown the cycle after its beat. A releasing tick reads the slot
//   memory (registered read) and then loads the output register from the read data;
//   the input stalls while that slot read is in flight.
// Reset: ring empty, pointers zero, elapsed saturated so the first queued
//   message leaves on the first tick, interval_ticks zero.
// Stall: a held result keeps its value; the input stalls while a result is
//   held and out_stall_i is high, or while a slot read is in flight.
module rate_limited_message_queue #(
  parameter int unsigned SLOTS = rlmq_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rlmq_pkg::in_item_t            in_data_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rlmq_pkg::out_item_t           out_data_o,
  // APB register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlmq_pkg::PaddrW-1:0]   paddr,
  input  logic [rlmq_pkg::PdataW-1:0]   pwdata,
  output logic [rlmq_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  rlmq_pkg::ctrl_state_e state_q, state_d;

  logic [rlmq_pkg::IntervalW-1:0] interval_q;
  logic [rlmq_pkg::IntervalW-1:0] elapsed_q, elapsed_d, elapsed_inc;

  logic                 out_valid_q, out_valid_d;
  rlmq_pkg::out_item_t  out_q, out_d;

  rlmq_pkg::ring_cmd_t       ring_cmd;
  rlmq_pkg::ring_sts_t       ring_sts;
  logic [rlmq_pkg::IdW-1:0]  ring_rd_data;

  logic in_beat, is_tick, is_arrival, release_now, cfg_wr;

  // --- APB registers; pready is tied high, index is paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite
                & (paddr[2] == rlmq_pkg::RegIntervalTicks);
  assign prdata = (paddr[2] == rlmq_pkg::RegIntervalTicks)
                ? {{(rlmq_pkg::PdataW - rlmq_pkg::IntervalW){1'b0}}, interval_q}
                : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
    end else if (cfg_wr) begin
      interval_q <= pwdata[rlmq_pkg::IntervalW-1:0];
    end
  end

  // --- input handshake: one item in flight, stall during slot fetch
  assign in_stall_o = (state_q != rlmq_pkg::StAccept) | (out_valid_q & out_stall_i);
  assign in_beat    = in_valid_i & ~in_stall_o;
  assign is_tick    = in_beat & (in_data_i.func == rlmq_pkg::FuncTick);
  assign is_arrival = in_beat & (in_data_i.func == rlmq_pkg::FuncArrival);

  // --- elapsed counter: saturating increment, then compare
  assign elapsed_inc = (elapsed_q == rlmq_pkg::ElapsedMax)
                     ? elapsed_q : elapsed_q + 1'b1;
  assign release_now = is_tick & ~ring_sts.empty & (elapsed_inc >= interval_q);

  always_comb begin
    elapsed_d = elapsed_q;
    if (is_tick) begin
      elapsed_d = release_now ? '0 : elapsed_inc;
    end
  end

  // --- ring commands
  assign ring_cmd.push = is_arrival & ~ring_sts.full;
  assign ring_cmd.pop  = release_now;

  rlmq_ring #(
    .Slots (SLOTS)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ring_cmd),
    .wr_data_i (in_data_i.msg_id),
    .sts_o     (ring_sts),
    .rd_data_o (ring_rd_data)
  );

  // --- sequencer: fetch state waits for the slot read data
  always_comb begin
    state_d = state_q;
    case (state_q)
      rlmq_pkg::StAccept: if (release_now) state_d = rlmq_pkg::StFetch;
      rlmq_pkg::StFetch:  state_d = rlmq_pkg::StAccept;
      default:            state_d = rlmq_pkg::StAccept;
    endcase
  end

  // --- output register: drop result on the beat, release after fetch
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    if (is_arrival & ring_sts.full) begin
      out_valid_d          = 1'b1;
      out_d.event_res      = rlmq_pkg::EvDropped;
      out_d.msg_id_out     = in_data_i.msg_id;
    end else if (state_q == rlmq_pkg::StFetch) begin
      out_valid_d          = 1'b1;
      out_d.event_res      = rlmq_pkg::EvReleased;
      out_d.msg_id_out     = ring_rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlmq_pkg::StAccept;
      elapsed_q   <= rlmq_pkg::ElapsedMax;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
